// File: hw/rtl/skvt_pkg.sv
// Package: shared constants, types and codes of the sorted key/value table.
package skvt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int KEY_BYTES     = 16;
  localparam int VALUE_BYTES   = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int ROW_W         = 256;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_FIND = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_LIST = 2'd3;

  localparam logic [1:0] RC_OK       = 2'd0;
  localparam logic [1:0] RC_NOTFOUND = 2'd1;
  localparam logic [1:0] RC_FULL     = 2'd2;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [63:0] out_key_high;
    logic [63:0] out_key_low;
    logic [63:0] out_value_high;
    logic [63:0] out_value_low;
    logic [5:0]  entry_total;
    logic        last_item;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic             load;      // capture the input item
    logic             clr_ptr;   // pointer to zero
    logic             ptr_cnt;   // pointer to count
    logic             ptr_inc;
    logic             ptr_dec;
    logic             rd;        // issue a read at the pointer
    logic             rd_next;   // read at pointer + 1
    logic             rd_prev;   // read at pointer - 1
    logic             wr_new;    // write captured item at pointer
    logic             wr_data;   // write last read row at pointer
    logic             cnt_inc;
    logic             cnt_dec;
    logic             emit;      // present result
    logic [1:0]       code;
    logic             emit_key;
    logic             emit_val;
    logic             emit_last;
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
    logic       ptr_zero;
    logic       ptr_at_end;   // pointer + 1 == count
    logic       ptr_ge_cnt;
    logic       rd_greater;   // read key > captured key
    logic       rd_equal;
    logic       out_busy;
  } sts_t;

  // Keep the top n bytes of a 128-bit word.
  function automatic logic [127:0] mask_top(input logic [127:0] w, input int n);
    logic [127:0] m;
    m = '0;
    for (int b = 0; b < 16; b++) begin
      if (b < n) m[127 - 8*b -: 8] = 8'hff;
    end
    return w & m;
  endfunction

endpackage

// File: hw/rtl/skvt_if.sv
// Interfaces: valid/ready channels of the sorted key/value table.
interface skvt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] value_high;
  logic [63:0] value_low;
  modport source (output valid, op, key_high, key_low, value_high, value_low, input ready);
  modport sink (input valid, op, key_high, key_low, value_high, value_low, output ready);
endinterface

interface skvt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [63:0] out_key_high;
  logic [63:0] out_key_low;
  logic [63:0] out_value_high;
  logic [63:0] out_value_low;
  logic [5:0]  entry_total;
  logic        last_item;
  modport source (output valid, result_code, out_key_high, out_key_low, out_value_high,
                  out_value_low, entry_total, last_item, input ready);
  modport sink (input valid, result_code, out_key_high, out_key_low, out_value_high,
                out_value_low, entry_total, last_item, output ready);
endinterface

// File: hw/rtl/skvt_ram.sv
// Generic single-port RAM with registered read.
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one row per cycle.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    else rdata <= mem[addr];
  end
endmodule

// File: hw/rtl/skvt_datapath.sv
// Datapath: entry memory, pointer, count, item capture and result register.
module skvt_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  skvt_pkg::cmd_t     cmd,
  output skvt_pkg::sts_t     sts,
  skvt_in_if.sink            in_ch,
  skvt_out_if.source         out_ch
);
  import skvt_pkg::*;

  logic [1:0]       op_r;
  logic [127:0]     key_r, val_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, ptr_r, ptr_nxt;
  logic [CNT_W-1:0] addr_full;
  logic             we;
  logic [ROW_W-1:0] wdata, rdata;
  logic             ov_r;
  out_item_t        oi_r;

  // Capture the item with its bytes masked.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_ch.op;
      key_r <= mask_top({in_ch.key_high, in_ch.key_low}, KEY_BYTES);
      val_r <= mask_top({in_ch.value_high, in_ch.value_low}, VALUE_BYTES);
    end
  end

  // Pointer and entry count.
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.clr_ptr) ptr_nxt = '0;
    else if (cmd.ptr_cnt) ptr_nxt = cnt_r;
    else if (cmd.ptr_inc) ptr_nxt = ptr_r + 1'b1;
    else if (cmd.ptr_dec) ptr_nxt = ptr_r - 1'b1;
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) cnt_nxt = cnt_r + 1'b1;
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  // One memory row holds key and value.
  always_comb begin
    we    = cmd.wr_new | cmd.wr_data;
    wdata = cmd.wr_new ? {key_r, val_r} : rdata;
    if (cmd.rd_next) addr_full = ptr_r + 1'b1;
    else if (cmd.rd_prev) addr_full = ptr_r - 1'b1;
    else addr_full = ptr_r;
  end

  skvt_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr_full[IDX_W-1:0]),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Result register; the count it reports is the one after this cycle's update.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      oi_r.result_code    <= cmd.code;
      {oi_r.out_key_high, oi_r.out_key_low} <= cmd.emit_key ? rdata[255:128] : '0;
      {oi_r.out_value_high, oi_r.out_value_low} <= cmd.emit_val ? rdata[127:0] : '0;
      oi_r.entry_total    <= 6'(cnt_nxt);
      oi_r.last_item      <= cmd.emit_last;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.result_code    = oi_r.result_code;
  assign out_ch.out_key_high   = oi_r.out_key_high;
  assign out_ch.out_key_low    = oi_r.out_key_low;
  assign out_ch.out_value_high = oi_r.out_value_high;
  assign out_ch.out_value_low  = oi_r.out_value_low;
  assign out_ch.entry_total    = oi_r.entry_total;
  assign out_ch.last_item      = oi_r.last_item;

  // Status.
  always_comb begin
    sts.op         = op_r;
    sts.full       = (cnt_r >= CNT_W'(TABLE_ENTRIES));
    sts.empty      = (cnt_r == '0);
    sts.ptr_zero   = (ptr_r == '0);
    sts.ptr_at_end = (ptr_r + 1'b1 == cnt_r);
    sts.ptr_ge_cnt = (ptr_r >= cnt_r);
    sts.rd_greater = (rdata[255:128] > key_r);
    sts.rd_equal   = (rdata[255:128] == key_r);
    sts.out_busy   = ov_r && !out_ch.ready;
  end
endmodule

// File: hw/rtl/skvt_ctrl.sv
// Controller: state machine that sequences add, find, delete and list.
module skvt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  skvt_pkg::sts_t  sts,
  output skvt_pkg::cmd_t  cmd
);
  import skvt_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_ARD   = 10'b0000000100,  // read row below insertion point
    S_ACHK  = 10'b0000001000,
    S_SRD   = 10'b0000010000,  // search: read at pointer
    S_SCHK  = 10'b0000100000,
    S_DRD   = 10'b0001000000,  // delete: read row above
    S_DWR   = 10'b0010000000,
    S_LCHK  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      // Choose the sequence for the captured operation.
      S_DISP: begin
        if (sts.out_busy) begin
          state_nxt = S_DISP;
        end else begin
          case (sts.op)
            OP_ADD: begin
              if (sts.full) begin
                cmd.emit = 1'b1; cmd.code = RC_FULL; cmd.emit_last = 1'b1;
                state_nxt = S_WAIT;
              end else begin
                cmd.ptr_cnt = 1'b1;
                state_nxt = S_ARD;
              end
            end
            OP_LIST: begin
              if (sts.empty) begin
                cmd.emit = 1'b1; cmd.code = RC_NOTFOUND; cmd.emit_last = 1'b1;
                state_nxt = S_WAIT;
              end else begin
                cmd.clr_ptr = 1'b1;
                state_nxt = S_SRD;
              end
            end
            default: begin
              cmd.clr_ptr = 1'b1;
              state_nxt = S_SRD;
            end
          endcase
        end
      end
      // Add: if the row below is larger, copy it up one slot.
      S_ARD: begin
        if (sts.ptr_zero) begin
          cmd.wr_new = 1'b1; cmd.cnt_inc = 1'b1;
          cmd.emit = 1'b1; cmd.code = RC_OK; cmd.emit_last = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.rd = 1'b1; cmd.rd_prev = 1'b1;
          state_nxt = S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.rd_greater) begin
          cmd.wr_data = 1'b1; cmd.ptr_dec = 1'b1;
          state_nxt = S_ARD;
        end else begin
          cmd.wr_new = 1'b1; cmd.cnt_inc = 1'b1;
          cmd.emit = 1'b1; cmd.code = RC_OK; cmd.emit_last = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      // Find, delete and list walk the rows from the bottom.
      S_SRD: begin
        if (sts.ptr_ge_cnt) begin
          cmd.emit = 1'b1; cmd.code = RC_NOTFOUND; cmd.emit_last = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = (sts.op == OP_LIST) ? S_LCHK : S_SCHK;
        end
      end
      S_SCHK: begin
        if (!sts.rd_equal) begin
          cmd.ptr_inc = 1'b1;
          state_nxt = S_SRD;
        end else if (sts.op == OP_FIND) begin
          cmd.emit = 1'b1; cmd.code = RC_OK; cmd.emit_val = 1'b1; cmd.emit_last = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_DRD;
        end
      end
      // Delete: pull each upper row down one slot.
      S_DRD: begin
        if (sts.ptr_at_end) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit = 1'b1; cmd.code = RC_OK; cmd.emit_last = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          cmd.rd = 1'b1; cmd.rd_next = 1'b1;
          state_nxt = S_DWR;
        end
      end
      S_DWR: begin
        cmd.wr_data = 1'b1; cmd.ptr_inc = 1'b1;
        state_nxt = S_DRD;
      end
      // List: one transfer per row, stalled by the result side.
      S_LCHK: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1; cmd.code = RC_OK; cmd.emit_key = 1'b1; cmd.emit_val = 1'b1;
          cmd.emit_last = sts.ptr_at_end;
          cmd.ptr_inc = 1'b1;
          state_nxt = sts.ptr_at_end ? S_WAIT : S_SRD;
        end
      end
      S_WAIT: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// File: hw/rtl/sorted_key_value_table_core.sv
// Top level of the sorted key/value table core.
// Holds up to 32 key/value entries in one 256-bit-wide single-port memory, kept in
// ascending key order. One command is worked on at a time. A find or delete walks the
// rows from the bottom, reading a row in S_SRD and comparing it in S_SCHK; an add moves
// each larger row up through S_ARD and S_ACHK; a delete pulls each upper row down
// through S_DRD and S_DWR; a list reads each row in S_SRD and hands it out from S_LCHK
// when the result side is free. No clearing pass is needed after reset.
module sorted_key_value_table_core (
  input  logic       clk,
  input  logic       rst_n,
  skvt_in_if.sink    in_ch,
  skvt_out_if.source out_ch
);
  import skvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skvt_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // A result is never overwritten while it waits for its transfer.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> !sts.out_busy)
    else $error("result overwritten");
  // Memory write and count change never collide with a new command capture.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.wr_new || cmd.wr_data || cmd.cnt_inc || cmd.cnt_dec))
    else $error("capture during table update");
  // Count never drops below zero.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.cnt_dec |-> !sts.empty)
    else $error("count underflow");
endmodule

// File: sim/skvt_tb_if.sv
// Testbench package: the command record that the stimulus queues for the driver.
package skvt_tb_types;
  import skvt_pkg::*;

  // One command to the table as it is queued for the driver.
  typedef struct {
    logic [1:0]  op;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [63:0] value_high;
    logic [63:0] value_low;
  } table_cmd_t;
endpackage

// File: sim/sorted_key_value_table_core_test.sv
// Testbench of the sorted key/value table core: directed and random commands checked against a table model.
module sorted_key_value_table_core_test;
  import skvt_pkg::*;
  import skvt_tb_types::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  skvt_in_if  in_ch();
  skvt_out_if out_ch();

  sorted_key_value_table_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // Clock.
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Table model state.
  logic [127:0] model_keys [TABLE_ENTRIES];
  logic [127:0] model_vals [TABLE_ENTRIES];
  int           model_count;

  table_cmd_t   pending_cmds [$];
  out_item_t    expected_results [$];
  int           error_count;
  bit           calm_phase;
  bit           hold_off;
  int           idle_cycles;

  // Key bytes (and value bytes) past the configured width are dropped.
  function automatic logic [127:0] keep_bytes(logic [63:0] hi, logic [63:0] lo, int n);
    logic [127:0] w;
    w = {hi, lo};
    for (int b = 0; b < 16; b++) begin
      if (b >= n) w[127 - 8*b -: 8] = 8'h00;
    end
    return w;
  endfunction

  function automatic out_item_t make_result(logic [1:0] code, logic [127:0] k,
                                            logic [127:0] v, logic last);
    out_item_t r;
    r.result_code    = code;
    r.out_key_high   = k[127:64];
    r.out_key_low    = k[63:0];
    r.out_value_high = v[127:64];
    r.out_value_low  = v[63:0];
    r.entry_total    = model_count[5:0];
    r.last_item      = last;
    return r;
  endfunction

  // Apply one accepted command to the model and queue the results it causes.
  task automatic apply_table_cmd(table_cmd_t c);
    logic [127:0] k;
    logic [127:0] v;
    int i;
    k = keep_bytes(c.key_high, c.key_low, KEY_BYTES);
    v = keep_bytes(c.value_high, c.value_low, VALUE_BYTES);
    i = 0;
    case (c.op)
      OP_ADD: begin
        if (model_count >= TABLE_ENTRIES) begin
          expected_results.push_back(make_result(RC_FULL, '0, '0, 1'b1));
        end else begin
          i = model_count;
          while (i > 0 && model_keys[i-1] > k) begin
            model_keys[i] = model_keys[i-1];
            model_vals[i] = model_vals[i-1];
            i--;
          end
          model_keys[i] = k;
          model_vals[i] = v;
          model_count++;
          expected_results.push_back(make_result(RC_OK, '0, '0, 1'b1));
        end
      end
      OP_FIND, OP_DEL: begin
        while (i < model_count && model_keys[i] != k) i++;
        if (i >= model_count) begin
          expected_results.push_back(make_result(RC_NOTFOUND, '0, '0, 1'b1));
        end else if (c.op == OP_FIND) begin
          expected_results.push_back(make_result(RC_OK, '0, model_vals[i], 1'b1));
        end else begin
          for (; i + 1 < model_count; i++) begin
            model_keys[i] = model_keys[i+1];
            model_vals[i] = model_vals[i+1];
          end
          model_count--;
          expected_results.push_back(make_result(RC_OK, '0, '0, 1'b1));
        end
      end
      default: begin
        if (model_count == 0) begin
          expected_results.push_back(make_result(RC_NOTFOUND, '0, '0, 1'b1));
        end else begin
          for (i = 0; i < model_count; i++) begin
            expected_results.push_back(make_result(RC_OK, model_keys[i], model_vals[i],
                                                   i + 1 == model_count));
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic queue_cmd(logic [1:0] op, logic [127:0] k, logic [127:0] v);
    table_cmd_t c;
    c.op = op;
    {c.key_high, c.key_low} = k;
    {c.value_high, c.value_low} = v;
    pending_cmds.push_back(c);
  endtask

  // Keys drawn mostly from small pools so finds and deletes hit often; one draw in four is fully random.
  function automatic logic [127:0] pool_key();
    logic [127:0] k;
    case ($urandom_range(0, 3))
      0: k = {$urandom(), $urandom(), $urandom(), $urandom()};
      1: k = {64'h0, 60'h0, 4'($urandom())};
      2: k = {60'h0, 4'($urandom()), 64'h0};
      default: k = {4'($urandom()), 124'h0} | 128'($urandom_range(0, 3));
    endcase
    return k;
  endfunction

  // Driver: inputs change on the falling edge; a transfer seen at the rising edge frees it.
  logic drv_busy;
  bit   in_taken;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_busy = 1'b0;
      in_taken = 1'b0;
    end else begin
      if (in_taken) begin
        drv_busy = 1'b0;
        in_taken = 1'b0;
      end
      if (!drv_busy) begin
        if (idle_cycles > 0) begin
          idle_cycles--;
          in_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && (calm_phase || $urandom_range(0, 5) != 0)) begin
          table_cmd_t c;
          c = pending_cmds.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.op         <= c.op;
          in_ch.key_high   <= c.key_high;
          in_ch.key_low    <= c.key_low;
          in_ch.value_high <= c.value_high;
          in_ch.value_low  <= c.value_low;
          drv_busy = 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
          if (!calm_phase && pending_cmds.size() > 0) idle_cycles = $urandom_range(0, 2);
        end
      end
    end
  end

  // Receiver ready: random stall bursts, a long hold-off when asked, none in the calm phase.
  int stall_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (calm_phase) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: accepted inputs feed the model, accepted results are checked.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles <= ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) ?
                      0 : quiet_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        table_cmd_t c;
        c.op = in_ch.op;
        c.key_high = in_ch.key_high;
        c.key_low = in_ch.key_low;
        c.value_high = in_ch.value_high;
        c.value_low = in_ch.value_low;
        apply_table_cmd(c);
        in_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_ch.result_code), 64'h0);
        end else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (out_ch.result_code !== e.result_code)
            report_mismatch("result_code", 64'(out_ch.result_code), 64'(e.result_code));
          if (out_ch.out_key_high !== e.out_key_high)
            report_mismatch("out_key_high", out_ch.out_key_high, e.out_key_high);
          if (out_ch.out_key_low !== e.out_key_low)
            report_mismatch("out_key_low", out_ch.out_key_low, e.out_key_low);
          if (out_ch.out_value_high !== e.out_value_high)
            report_mismatch("out_value_high", out_ch.out_value_high, e.out_value_high);
          if (out_ch.out_value_low !== e.out_value_low)
            report_mismatch("out_value_low", out_ch.out_value_low, e.out_value_low);
          if (out_ch.entry_total !== e.entry_total)
            report_mismatch("entry_total", 64'(out_ch.entry_total), 64'(e.entry_total));
          if (out_ch.last_item !== e.last_item)
            report_mismatch("last_item", 64'(out_ch.last_item), 64'(e.last_item));
        end
      end
    end
  end

  // Watchdog on cycles with no transfer.
  always @(posedge clk) begin
    if (rst_n && quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [127:0] all_ones;
    all_ones = '1;
    error_count = 0;
    quiet_cycles = 0;
    idle_cycles = 0;
    calm_phase = 1'b0;
    hold_off = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.key_high = '0;
    in_ch.key_low = '0;
    in_ch.value_high = '0;
    in_ch.value_low = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty list, misses, extremes, duplicates, full table.
    queue_cmd(OP_LIST, '0, '0);
    queue_cmd(OP_FIND, '0, '0);
    queue_cmd(OP_DEL, all_ones, '0);
    queue_cmd(OP_ADD, all_ones, all_ones);
    queue_cmd(OP_ADD, '0, '0);
    queue_cmd(OP_ADD, 128'h5, 128'h11);
    queue_cmd(OP_ADD, 128'h5, 128'h22);
    queue_cmd(OP_FIND, 128'h5, '0);
    queue_cmd(OP_FIND, all_ones, '0);
    queue_cmd(OP_LIST, '0, '0);
    queue_cmd(OP_DEL, 128'h5, '0);
    queue_cmd(OP_FIND, 128'h5, '0);
    queue_cmd(OP_DEL, '0, '0);
    queue_cmd(OP_DEL, all_ones, '0);
    queue_cmd(OP_DEL, 128'h5, '0);
    for (int i = 0; i < TABLE_ENTRIES + 1; i++)
      queue_cmd(OP_ADD, {$urandom(), $urandom(), $urandom(), $urandom()},
                {$urandom(), $urandom(), $urandom(), $urandom()});
    queue_cmd(OP_LIST, '0, '0);

    // Long hold-off on the receiver while the sender keeps offering.
    wait (pending_cmds.size() < 6);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;

    // Random part: a mixed workload of adds, finds, deletes and lists, ending in a calm phase.
    for (int i = 0; i < 400; i++) begin
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 8)
        queue_cmd(OP_ADD, pool_key(), {$urandom(), $urandom(), $urandom(), $urandom()});
      else if (pick < 12) queue_cmd(OP_FIND, pool_key(), '0);
      else if (pick < 18) queue_cmd(OP_DEL, pool_key(), '0);
      else queue_cmd(OP_LIST, '0, '0);
      if (i == 330) begin
        wait (pending_cmds.size() < 20);
        calm_phase = 1'b1;
      end
    end

    wait (pending_cmds.size() == 0 && !drv_busy);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/skvt_pkg.sv
hw/rtl/skvt_if.sv
hw/rtl/skvt_ram.sv
hw/rtl/skvt_datapath.sv
hw/rtl/skvt_ctrl.sv
hw/rtl/sorted_key_value_table_core.sv
sim/skvt_tb_if.sv
sim/sorted_key_value_table_core_test.sv
